// ===== hdl/byte_stack_machine_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the byte stack machine core
// Clocked, reset-qualified property wrappers.
// ---------------------------------------------------------------------------
`ifndef BYTE_STACK_MACHINE_CORE_ASSERT_SVH
`define BYTE_STACK_MACHINE_CORE_ASSERT_SVH
// Implication checked on every rising edge outside reset
`define BSM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset
`define BSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hdl/bsm_pkg.sv =====
// ---------------------------------------------------------------------------
// bsm_pkg
// Shared types, opcodes and constants of the byte stack machine.
// ---------------------------------------------------------------------------
package bsm_pkg;
	localparam int StackDepth = 64;
	localparam int SpW = $clog2(StackDepth + 1);
	localparam int SaW = $clog2(StackDepth);

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_STEP  = 2'd2;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_UNDER = 2'd1;
	localparam logic [1:0] ERR_OVER  = 2'd2;
	localparam logic [1:0] ERR_DIV0  = 2'd3;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_NUM  = 2'd1;
	localparam logic [1:0] KIND_CHR  = 2'd2;

	typedef enum logic [4:0] {
		OP_NOP, OP_DIGIT, OP_JOIN, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
		OP_AND, OP_OR, OP_XOR, OP_NOT, OP_LNOT, OP_READ, OP_PNUM, OP_PCHR,
		OP_DUP, OP_DROP, OP_SWAP, OP_JMP, OP_JCOND, OP_PC, OP_LOAD,
		OP_STORE, OP_BAD
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] pops;
		logic [1:0] pushes;
		logic [3:0] digit;
	} dec_t;

	function automatic dec_t decode(input logic [7:0] c);
		dec_t d;
		d = '{op: OP_BAD, pops: 2'd0, pushes: 2'd0, digit: 4'd0};
		if (c >= 8'h30 && c <= 8'h39) begin
			d.op = OP_DIGIT; d.pushes = 2'd1; d.digit = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d.op = OP_DIGIT; d.pushes = 2'd1; d.digit = 4'(c - 8'h57);
		end else begin
			unique case (c)
				8'h20: d.op = OP_NOP;
				8'h2e: begin d.op = OP_JOIN; d.pops = 2'd2; d.pushes = 2'd1; end
				8'h2b: begin d.op = OP_ADD;  d.pops = 2'd2; d.pushes = 2'd1; end
				8'h2d: begin d.op = OP_SUB;  d.pops = 2'd2; d.pushes = 2'd1; end
				8'h2a: begin d.op = OP_MUL;  d.pops = 2'd2; d.pushes = 2'd1; end
				8'h2f: begin d.op = OP_DIV;  d.pops = 2'd2; d.pushes = 2'd1; end
				8'h25: begin d.op = OP_MOD;  d.pops = 2'd2; d.pushes = 2'd1; end
				8'h26: begin d.op = OP_AND;  d.pops = 2'd2; d.pushes = 2'd1; end
				8'h7c: begin d.op = OP_OR;   d.pops = 2'd2; d.pushes = 2'd1; end
				8'h58: begin d.op = OP_XOR;  d.pops = 2'd2; d.pushes = 2'd1; end
				8'h7e: begin d.op = OP_NOT;  d.pops = 2'd1; d.pushes = 2'd1; end
				8'h21: begin d.op = OP_LNOT; d.pops = 2'd1; d.pushes = 2'd1; end
				8'h6c: begin d.op = OP_LOAD; d.pops = 2'd1; d.pushes = 2'd1; end
				8'h72: begin d.op = OP_READ; d.pushes = 2'd1; end
				8'h49: begin d.op = OP_PC;   d.pushes = 2'd1; end
				8'h70: begin d.op = OP_PNUM; d.pops = 2'd1; end
				8'h27: begin d.op = OP_PCHR; d.pops = 2'd1; end
				8'h29: begin d.op = OP_DROP; d.pops = 2'd1; end
				8'h67: begin d.op = OP_JMP;  d.pops = 2'd1; end
				8'h28: begin d.op = OP_DUP;  d.pops = 2'd1; d.pushes = 2'd2; end
				8'h40: begin d.op = OP_SWAP; d.pops = 2'd2; d.pushes = 2'd2; end
				8'h6a: begin d.op = OP_JCOND; d.pops = 2'd2; end
				8'h73: begin d.op = OP_STORE; d.pops = 2'd2; end
				default: d.op = OP_BAD;
			endcase
		end
		return d;
	endfunction

	// controller -> datapath commands
	typedef struct packed {
		logic cap_in;      // hold the data field of an accepted item
		logic clr_start;   // start item: reset pc, sp, flags
		logic mem_load;    // write input byte to memory
		logic fetch;       // read memory at pc
		logic latch_op;    // decode fetched byte, check stack
		logic rd_a;        // read top of stack
		logic rd_b;        // read second entry
		logic cap_a;       // capture a
		logic cap_b;       // capture b
		logic div_start;
		logic mem_rd_a;    // memory read at a (load)
		logic execute;     // write back results
		logic wr_r1;       // second push
		logic cap_out;     // latch result item
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic       halted;
		logic       fault;     // decode, stack or divide-by-zero check halts this step
		logic [1:0] pops;
		logic [1:0] pushes;
		logic       is_div;
		logic       is_load;
		logic       div_done;
	} sts_t;
endpackage

// ===== hdl/bsm_divider.sv =====
// ---------------------------------------------------------------------------
// bsm_divider
// Restoring 8-bit divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bsm_divider
	import bsm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [7:0] dividend,
	input  logic [7:0] divisor,
	output logic       done,
	output logic [7:0] quotient,
	output logic [7:0] remainder
);
	logic [3:0] cnt_q;
	logic       busy_q;
	logic [7:0] quo_q, rem_q, dsr_q;
	logic [8:0] trial;

	assign trial = {rem_q, quo_q[7]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd7) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= 8'd0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// shift one dividend bit in; keep the difference when it fits
			if (!trial[8]) begin
				rem_q <= trial[7:0];
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				rem_q <= {rem_q[6:0], quo_q[7]};
				quo_q <= {quo_q[6:0], 1'b0};
			end
		end
	end

	assign done      = !busy_q && !start;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

// ===== hdl/bsm_datapath.sv =====
// ---------------------------------------------------------------------------
// bsm_datapath
// Memory, stack, registers, ALU and result register of the stack machine.
// ---------------------------------------------------------------------------
module bsm_datapath
	import bsm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic [7:0] address,
	input  logic [7:0] data,
	output sts_t       sts,
	output logic [1:0] out_kind,
	output logic [7:0] out_byte,
	output logic       used_data,
	output logic       halted,
	output logic [1:0] error_code,
	output logic [7:0] program_counter
);
	logic [7:0]     mem [256];
	logic [255:0]   mem_vld_q;   // entry not valid reads as zero
	logic [7:0]     mem_rd_q;
	logic [7:0]     mem_addr_q;
	logic [7:0]     stk [StackDepth];
	logic [7:0]     stk_rd_q;
	logic [SpW-1:0] sp_q;
	logic [7:0]     pc_q;
	logic           halt_q;
	logic [1:0]     err_q;
	dec_t           dec_q;
	logic [7:0]     a_q, b_q, r1_q;
	logic [7:0]     dat_q;
	logic           fault_q;
	logic [7:0]     mem_wa, mem_wd, mem_ra;
	logic           mem_we;
	logic [SaW-1:0] stk_ra, stk_wa;
	logic [7:0]     stk_wd;
	logic           stk_we;
	logic [7:0]     mem_byte;
	logic [7:0]     r0, nxt_pc;
	logic [SpW-1:0] sp_after;
	logic           div_done;
	logic [7:0]     quo, rem;
	dec_t           dec_now;
	logic [SpW:0]   depth_need;

	assign mem_byte = mem_vld_q[mem_addr_q] ? mem_rd_q : 8'd0;

	// memory port
	always_comb begin
		mem_we = 1'b0;
		mem_wa = address;
		mem_wd = data;
		if (cmd.mem_load) mem_we = 1'b1;
		else if (cmd.execute && dec_q.op == OP_STORE && !fault_q) begin
			mem_we = 1'b1; mem_wa = a_q; mem_wd = b_q;
		end
		mem_ra = cmd.mem_rd_a ? a_q : pc_q;
	end

	// hold the read byte until the next fetch or load read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (cmd.fetch || cmd.mem_rd_a) mem_rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_vld_q  <= '0;
			mem_addr_q <= 8'd0;
		end else begin
			if (mem_we) mem_vld_q[mem_wa] <= 1'b1;
			if (cmd.fetch || cmd.mem_rd_a) mem_addr_q <= mem_ra;
		end
	end

	// decode of fetched byte and stack limit check
	assign dec_now    = decode(mem_byte);
	assign depth_need = {1'b0, sp_q} - (SpW+1)'(dec_now.pops) + (SpW+1)'(dec_now.pushes);

	bsm_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(b_q), .divisor(a_q),
		.done(div_done), .quotient(quo), .remainder(rem)
	);

	// stack port
	assign sp_after = sp_q - SpW'(dec_q.pops);
	always_comb begin
		stk_ra = cmd.rd_b ? SaW'(sp_q - SpW'(2)) : SaW'(sp_q - SpW'(1));
		stk_we = 1'b0;
		stk_wa = SaW'(sp_after);
		stk_wd = r0;
		if (cmd.execute && !fault_q && dec_q.pushes != 2'd0) stk_we = 1'b1;
		if (cmd.wr_r1) begin
			stk_we = 1'b1; stk_wa = SaW'(sp_q - SpW'(1)); stk_wd = r1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) stk[stk_wa] <= stk_wd;
		stk_rd_q <= stk[stk_ra];
	end

	// ALU
	always_comb begin
		r0     = 8'd0;
		nxt_pc = pc_q + 8'd1;
		unique case (dec_q.op)
			OP_DIGIT: r0 = {4'd0, dec_q.digit};
			OP_JOIN:  r0 = {b_q[3:0], 4'd0} | a_q;
			OP_ADD:   r0 = b_q + a_q;
			OP_SUB:   r0 = b_q - a_q;
			OP_MUL:   r0 = 8'(b_q * a_q);
			OP_DIV:   r0 = quo;
			OP_MOD:   r0 = rem;
			OP_AND:   r0 = b_q & a_q;
			OP_OR:    r0 = b_q | a_q;
			OP_XOR:   r0 = b_q ^ a_q;
			OP_NOT:   r0 = ~a_q;
			OP_LNOT:  r0 = {7'd0, a_q == 8'd0};
			OP_READ:  r0 = dat_q;
			OP_PC:    r0 = pc_q;
			OP_LOAD:  r0 = mem_byte;
			OP_DUP:   r0 = a_q;
			OP_SWAP:  r0 = a_q;
			OP_JMP:   nxt_pc = a_q;
			OP_JCOND: if (b_q != 8'd0) nxt_pc = a_q;
			default:  r0 = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q    <= '0;
			pc_q    <= 8'd0;
			halt_q  <= 1'b1;
			err_q   <= ERR_NONE;
			fault_q <= 1'b0;
			dec_q   <= '{op: OP_NOP, pops: 2'd0, pushes: 2'd0, digit: 4'd0};
		end else begin
			if (cmd.clr_start) begin
				sp_q <= '0; pc_q <= 8'd0; halt_q <= 1'b0; err_q <= ERR_NONE;
			end
			if (cmd.latch_op) begin
				dec_q   <= dec_now;
				fault_q <= 1'b1;
				halt_q  <= 1'b1;
				if (dec_now.op == OP_BAD) err_q <= ERR_NONE;
				else if ({1'b0, sp_q} < (SpW+1)'(dec_now.pops)) err_q <= ERR_UNDER;
				else if (depth_need > (SpW+1)'(StackDepth)) err_q <= ERR_OVER;
				else begin
					fault_q <= 1'b0;
					halt_q  <= 1'b0;
				end
			end
			if (cmd.cap_a && !fault_q) begin
				if ((dec_q.op == OP_DIV || dec_q.op == OP_MOD) && stk_rd_q == 8'd0) begin
					fault_q <= 1'b1; halt_q <= 1'b1; err_q <= ERR_DIV0;
				end
			end
			if (cmd.execute && !fault_q) begin
				sp_q <= sp_after + SpW'(dec_q.pushes);
				pc_q <= nxt_pc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) dat_q <= data;
		if (cmd.cap_a) a_q <= stk_rd_q;
		if (cmd.cap_b) b_q <= stk_rd_q;
		if (cmd.execute) r1_q <= (dec_q.op == OP_SWAP) ? b_q : a_q;
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.cap_out) begin
			out_kind  <= KIND_NONE;
			out_byte  <= 8'd0;
			used_data <= 1'b0;
			if (cmd.execute && !fault_q) begin
				if (dec_q.op == OP_PNUM) begin out_kind <= KIND_NUM; out_byte <= a_q; end
				if (dec_q.op == OP_PCHR) begin out_kind <= KIND_CHR; out_byte <= a_q; end
				used_data <= (dec_q.op == OP_READ);
			end
		end
	end

	assign halted          = halt_q;
	assign error_code      = err_q;
	assign program_counter = pc_q;

	assign sts.halted   = halt_q;
	assign sts.fault    = fault_q;
	assign sts.pops     = dec_q.pops;
	assign sts.pushes   = dec_q.pushes;
	assign sts.is_div   = (dec_q.op == OP_DIV) || (dec_q.op == OP_MOD);
	assign sts.is_load  = (dec_q.op == OP_LOAD);
	assign sts.div_done = div_done;
endmodule

// ===== hdl/bsm_control.sv =====
// ---------------------------------------------------------------------------
// bsm_control
// Sequencer for one item: handshake, fetch, stack reads, execute, result.
// ---------------------------------------------------------------------------
module bsm_control
	import bsm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	output logic       out_valid,
	input  logic       out_ready,
	input  sts_t       sts,
	output cmd_t       cmd
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_FETCH = 10'b0000000010,
		S_DEC   = 10'b0000000100,
		S_RDA   = 10'b0000001000,
		S_RDB   = 10'b0000010000,
		S_CAPB  = 10'b0000100000,
		S_DIV   = 10'b0001000000,
		S_MEM   = 10'b0010000000,
		S_EXEC  = 10'b0100000000,
		S_PUSH2 = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q, fin;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		fin     = 1'b0;
		unique case (state_q)
			S_IDLE: if (in_valid && in_ready) begin
				cmd.cap_in    = 1'b1;
				cmd.clr_start = (mode == MODE_START);
				cmd.mem_load  = (mode == MODE_LOAD);
				if (mode == MODE_STEP && !sts.halted) state_d = S_FETCH;
				else begin cmd.cap_out = 1'b1; fin = 1'b1; end
			end
			S_FETCH: begin cmd.fetch = 1'b1; state_d = S_DEC; end
			S_DEC: begin
				cmd.latch_op = 1'b1; cmd.rd_a = 1'b1; state_d = S_RDA;
			end
			S_RDA: begin
				if (sts.fault) begin
					cmd.cap_out = 1'b1; fin = 1'b1; state_d = S_IDLE;
				end else begin
					cmd.cap_a = 1'b1; cmd.rd_b = 1'b1; state_d = S_RDB;
				end
			end
			S_RDB: begin
				if (sts.fault) begin
					cmd.cap_out = 1'b1; fin = 1'b1; state_d = S_IDLE;
				end else begin
					cmd.cap_b = 1'b1; state_d = S_CAPB;
				end
			end
			S_CAPB: begin
				if (sts.is_div) begin cmd.div_start = 1'b1; state_d = S_DIV; end
				else if (sts.is_load) begin cmd.mem_rd_a = 1'b1; state_d = S_MEM; end
				else state_d = S_EXEC;
			end
			S_DIV: if (sts.div_done) state_d = S_EXEC;
			S_MEM: state_d = S_EXEC;
			S_EXEC: begin
				cmd.execute = 1'b1; cmd.cap_out = 1'b1;
				if (sts.pushes == 2'd2) state_d = S_PUSH2;
				else begin fin = 1'b1; state_d = S_IDLE; end
			end
			S_PUSH2: begin cmd.wr_r1 = 1'b1; fin = 1'b1; state_d = S_IDLE; end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

// ===== hdl/byte_stack_machine_core.sv =====
// ---------------------------------------------------------------------------
// byte_stack_machine_core
// 8-bit stack machine with shared 256-byte code/data memory.
// ---------------------------------------------------------------------------
// Channel | Handshake            | Payload
// in      | in_valid / in_ready   | mode, address, data
// out     | out_valid / out_ready | out_kind, out_byte, used_data, halted,
//         |                       | error_code, program_counter
//
// Load, start, idle steps and unused modes give a result in the cycle after they
// are taken. An executed step runs fetch, decode, two stack reads and execute,
// plus a memory read for load, a second push for duplicate and swap, and the
// bit-serial divider for divide and modulo; a fault ends it after a stack read.
// Memory reads as zero after reset through per-byte valid flags; no sweep.
// A held result blocks the next item only until it is taken.
// ---------------------------------------------------------------------------
module byte_stack_machine_core
	import bsm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [7:0] address,
	input  logic [7:0] data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] out_kind,
	output logic [7:0] out_byte,
	output logic       used_data,
	output logic       halted,
	output logic [1:0] error_code,
	output logic [7:0] program_counter
);
`include "byte_stack_machine_core_assert.svh"

	cmd_t cmd;
	sts_t sts;
	logic start_acc;
	logic start_ok;

	// sequence each item
	bsm_control u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	// hold memory, stack and registers
	bsm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .address(address), .data(data),
		.sts(sts), .out_kind(out_kind), .out_byte(out_byte),
		.used_data(used_data), .halted(halted), .error_code(error_code),
		.program_counter(program_counter)
	);

	// a start item leaves the machine running at address zero with no error
	assign start_acc = in_valid && in_ready && (mode == MODE_START);
	assign start_ok  = !halted && (error_code == ERR_NONE) && (program_counter == 8'd0);

	`BSM_ASSERT_IMP(a_err_halts, out_valid && error_code != ERR_NONE, halted, "error without halt")
	`BSM_ASSERT_IMP(a_print_running, out_valid && out_kind != KIND_NONE, !halted, "print on fault")
	`BSM_ASSERT_NEXT(a_start_clears, start_acc, start_ok, "start did not clear")
endmodule

// ===== tb/tb_byte_stack_machine_core.sv =====
// ---------------------------------------------------------------------------
// tb_byte_stack_machine_core
// Self-checking bench: loads small programs, starts and steps them, and
// compares every result item with the in-bench model or a hand-typed row.
// ---------------------------------------------------------------------------
module tb_byte_stack_machine_core;
	import bsm_pkg::*;

	localparam int WatchdogLimit = 2000;
	localparam int ItemsTarget   = 1250;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] pbyte;
		logic       rd;
		logic       hlt;
		logic [1:0] err;
		logic [7:0] pc;
		logic       chk; // directed row with a hand-typed expectation
	} res_t;

	typedef struct {
		logic [1:0] mode;
		logic [7:0] addr;
		logic [7:0] dat;
		logic       chk;
		res_t       want;
	} row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] mode;
	logic [7:0] address;
	logic [7:0] data;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic       used_data;
	logic       halted;
	logic [1:0] error_code;
	logic [7:0] program_counter;

	// model state
	logic [7:0] mem_m [256];
	logic [7:0] stk_m [StackDepth];
	int         sp_m;
	logic [7:0] pc_m;
	logic       hlt_m;
	logic [1:0] err_m;

	res_t       pending_results[$];
	int         failures;
	int         idle_cycles;
	int         items_sent;

	byte_stack_machine_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_legal(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
			c inside {" ", ".", "+", "-", "*", "/", "%", "&", "|", "X", "~", "!",
			"r", "p", "'", "(", ")", "@", "g", "j", "I", "l", "s"};
	endfunction

	// Advance the model by one item and return the result it predicts.
	function automatic res_t machine_step(input logic [1:0] md, input logic [7:0] ad,
			input logic [7:0] dt);
		res_t       r;
		logic [7:0] op, a, b, r0, r1, nxt;
		int         pops, pushes;
		r = '{default: '0};
		if (md == MODE_LOAD) begin
			mem_m[ad] = dt;
		end else if (md == MODE_START) begin
			pc_m = 8'd0; sp_m = 0; hlt_m = 1'b0; err_m = ERR_NONE;
		end else if (md == MODE_STEP && !hlt_m) begin
			op = mem_m[pc_m]; pops = 0; pushes = 0; a = 0; b = 0; r0 = 0; r1 = 0;
			nxt = pc_m + 8'd1;
			if ((op >= "0" && op <= "9") || (op >= "a" && op <= "f") || op == "r" ||
					op == "I") pushes = 1;
			else if (op inside {".", "+", "-", "*", "/", "%", "&", "|", "X"}) begin
				pops = 2; pushes = 1;
			end else if (op inside {"~", "!", "l"}) begin
				pops = 1; pushes = 1;
			end else if (op inside {"p", "'", ")", "g"}) pops = 1;
			else if (op == "(") begin
				pops = 1; pushes = 2;
			end else if (op == "@") begin
				pops = 2; pushes = 2;
			end else if (op inside {"j", "s"}) pops = 2;
			if (!is_legal(op)) begin
				hlt_m = 1'b1; err_m = ERR_NONE;
			end else if (sp_m < pops) begin
				hlt_m = 1'b1; err_m = ERR_UNDER;
			end else if (sp_m - pops + pushes > StackDepth) begin
				hlt_m = 1'b1; err_m = ERR_OVER;
			end else begin
				if (pops >= 1) a = stk_m[sp_m - 1];
				if (pops >= 2) b = stk_m[sp_m - 2];
				if ((op == "/" || op == "%") && a == 0) begin
					hlt_m = 1'b1; err_m = ERR_DIV0;
				end else begin
					case (op)
						".": r0 = {b[3:0], 4'd0} | a;
						"+": r0 = b + a;
						"-": r0 = b - a;
						"*": r0 = b * a;
						"/": r0 = b / a;
						"%": r0 = b % a;
						"&": r0 = b & a;
						"|": r0 = b | a;
						"X": r0 = b ^ a;
						"~": r0 = ~a;
						"!": r0 = (a == 0);
						"r": begin r0 = dt; r.rd = 1'b1; end
						"I": r0 = pc_m;
						"l": r0 = mem_m[a];
						"(": begin r0 = a; r1 = a; end
						"@": begin r0 = a; r1 = b; end
						"p": begin r.kind = KIND_NUM; r.pbyte = a; end
						"'": begin r.kind = KIND_CHR; r.pbyte = a; end
						"g": nxt = a;
						"j": if (b != 0) nxt = a;
						"s": mem_m[a] = b;
						default:
							if (op >= "0" && op <= "9") r0 = op - "0";
							else if (op >= "a" && op <= "f") r0 = op - "a" + 10;
					endcase
					sp_m -= pops;
					if (pushes >= 1) stk_m[sp_m++] = r0;
					if (pushes >= 2) stk_m[sp_m++] = r1;
					pc_m = nxt;
				end
			end
		end
		r.hlt = hlt_m; r.err = err_m; r.pc = pc_m;
		return r;
	endfunction

	// Present one item, hold it until taken, and queue its expectation.
	task automatic send_item(input logic [1:0] md, input logic [7:0] ad,
			input logic [7:0] dt, input logic chk, input res_t want);
		res_t pred;
		int   n;
		n = $urandom_range(0, 7);
		if (n != 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= md; address <= ad; data <= dt;
		do @(posedge clk); while (!in_ready);
		pred = machine_step(md, ad, dt);
		items_sent++;
		if (chk) begin
			want.chk = 1'b1;
			pending_results.push_back(want);
		end else pending_results.push_back(pred);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Random stack program of mostly legal opcodes, then a start and a run of items, mostly steps.
	task automatic run_program();
		string  legal;
		int     len, nsteps;
		logic [7:0] b;
		res_t   none;
		legal = "0123456789abcdef .+-*/%&|X~!rp'()@gjIls";
		none = '{default: '0};
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 255) : $urandom_range(4, 24);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0) b = 8'($urandom_range(0, 255));
			else if ($urandom_range(0, 2) == 0) b = legal[$urandom_range(0, 15)];
			else b = legal[$urandom_range(0, legal.len() - 1)];
			send_item(MODE_LOAD, i[7:0], b, 1'b0, none);
		end
		send_item(MODE_START, 8'($urandom), 8'($urandom), 1'b0, none);
		nsteps = $urandom_range(5, 40);
		for (int i = 0; i < nsteps; i++) begin
			case ($urandom_range(0, 29))
				0: send_item(MODE_LOAD, 8'($urandom), 8'($urandom), 1'b0, none);
				1: send_item(2'd3, 8'($urandom), 8'($urandom), 1'b0, none);
				default: send_item(MODE_STEP, 8'($urandom), 8'($urandom), 1'b0, none);
			endcase
		end
	endtask

	// Results: draw a wait per item, compare against the oldest expectation.
	initial begin
		res_t w;
		int   n;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			n = $urandom_range(0, 7);
			if (n != 0) begin
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(arst_n && out_valid));
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result item pc=%0d", $time, program_counter);
				failures++;
			end else begin
				w = pending_results.pop_front();
				if (out_kind !== w.kind || out_byte !== w.pbyte || used_data !== w.rd ||
						halted !== w.hlt || error_code !== w.err ||
						program_counter !== w.pc) begin
					$display("%0t: mismatch exp kind=%0d byte=%0d rd=%0d hlt=%0d err=%0d pc=%0d",
						$time, w.kind, w.pbyte, w.rd, w.hlt, w.err, w.pc);
					$display("%0t:          act kind=%0d byte=%0d rd=%0d hlt=%0d err=%0d pc=%0d",
						$time, out_kind, out_byte, used_data, halted, error_code,
						program_counter);
					failures++;
				end
			end
		end
	end

	// Watchdog: count cycles with no handshake on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("byte_stack_machine_core regression: fail");
			$finish;
		end
	end

	initial begin
		row_t table_rows[$];
		string prog;
		res_t  x;
		failures = 0; idle_cycles = 0; items_sent = 0;
		in_valid = 1'b0; mode = '0; address = '0; data = '0;
		arst_n = 1'b0;
		foreach (mem_m[i]) mem_m[i] = '0;
		foreach (stk_m[i]) stk_m[i] = '0;
		sp_m = 0; pc_m = '0; hlt_m = 1'b1; err_m = ERR_NONE;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed: step while halted, unused mode, start, unknown byte from zero memory.
		x = '{default: '0};
		x.hlt = 1'b1;
		table_rows.push_back('{MODE_STEP, 8'hff, 8'hff, 1'b1, x});
		table_rows.push_back('{2'd3, 8'h00, 8'h00, 1'b1, x});
		x.hlt = 1'b0;
		table_rows.push_back('{MODE_START, 8'h00, 8'h00, 1'b1, x});
		x.hlt = 1'b1;
		table_rows.push_back('{MODE_STEP, 8'h00, 8'h00, 1'b1, x}); // byte 0 halts
		// Program holding every opcode; the run halts on underflow at the first &.
		prog = "ff.r(+p7@-c*3/5%'9&6|X~!I)1 ls0l4gj@";
		for (int i = 0; i < prog.len(); i++)
			table_rows.push_back('{MODE_LOAD, i[7:0], prog[i], 1'b0, x});
		table_rows.push_back('{MODE_START, 8'hff, 8'hff, 1'b0, x});
		for (int i = 0; i < 24; i++)
			table_rows.push_back('{MODE_STEP, 8'h00, (i % 2) ? 8'hff : 8'h00, 1'b0, x});
		foreach (table_rows[i])
			send_item(table_rows[i].mode, table_rows[i].addr, table_rows[i].dat,
				table_rows[i].chk, table_rows[i].want);

		// Divide by zero, then a loop that grows the stack until it overflows.
		x = '{default: '0};
		prog = "10/";
		for (int i = 0; i < 3; i++) send_item(MODE_LOAD, i[7:0], prog[i], 1'b0, x);
		send_item(MODE_START, 8'h00, 8'h00, 1'b0, x);
		repeat (3) send_item(MODE_STEP, 8'h00, 8'h00, 1'b0, x);
		send_item(MODE_LOAD, 8'h00, "1", 1'b0, x);
		send_item(MODE_LOAD, 8'h01, "(", 1'b0, x);
		send_item(MODE_LOAD, 8'h02, "(", 1'b0, x);
		send_item(MODE_LOAD, 8'h03, "1", 1'b0, x);
		send_item(MODE_LOAD, 8'h04, "g", 1'b0, x);
		send_item(MODE_START, 8'h00, 8'h00, 1'b0, x);
		repeat (140) send_item(MODE_STEP, 8'h00, 8'h00, 1'b0, x);

		// Hold off the sender until every result is back.
		wait_drained();

		while (items_sent < ItemsTarget) begin
			run_program();
			if ($urandom_range(0, 9) == 0) wait_drained();
		end

		wait_drained();
		if (failures == 0) $display("byte_stack_machine_core regression: pass");
		else $display("byte_stack_machine_core regression: fail");
		$finish;
	end
endmodule
